// ===== rtl/core/chbf_pkg.sv =====
// ----------------------------------------------------------------------------
// chbf_pkg
// Shared types and constants for the brute-force convex hull marker.
// ----------------------------------------------------------------------------
package chbf_pkg;

  // Fixed field widths of the external transactions and the status count
  localparam int COORD_IN_W  = 16;
  localparam int HULL_IDX_W  = 6;
  localparam int CNT_FIELD_W = 7;

  // One input transaction: a point, the last of its set marked
  typedef struct packed {
    logic signed [COORD_IN_W-1:0] x_coord;
    logic signed [COORD_IN_W-1:0] y_coord;
    logic                         set_end;
  } in_item_t;

  // One result transaction: a hull point index
  typedef struct packed {
    logic [HULL_IDX_W-1:0] hull_index;
    logic                  run_end;
    logic                  overflow;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                  load;
    logic                  rd_en;
    logic [HULL_IDX_W-1:0] rd_addr;
    logic                  lat_i;
    logic                  lat_j;
    logic                  set_pair;
    logic                  k_issue;
    logic                  mark_pair;
    logic [HULL_IDX_W-1:0] pair_i;
    logic [HULL_IDX_W-1:0] pair_j;
    logic                  scan_en;
    logic [HULL_IDX_W-1:0] scan_idx;
    logic                  flush;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CNT_FIELD_W-1:0] count;
    logic                   pipe_busy;
    logic                   coincident;
    logic                   opposite;
  } dp_sts_t;

endpackage

// ===== rtl/core/convex_hull_brute_force.sv =====
// ----------------------------------------------------------------------------
// convex_hull_brute_force
// Loads a set of 2D points and reports the indices of its hull points.
// ----------------------------------------------------------------------------
//  channel  ports                        handshake
//  input    in_payload, start, busy      taken when start && !busy
//  result   out_payload, out_strobe      one cycle per transaction, no stall
//
//  Loading takes a point whenever start is high and busy is low. A set_end
//  point starts the hull pass: each of the n(n-1)/2 pairs whose points do not
//  coincide is tested against every stored point, bounded by the single read
//  port of the point store, which serves one test point per cycle; then the
//  marked indices are scanned out. busy is high for the whole pass. Reset is
//  synchronous and clears the set state; no clearing pass is needed. Results
//  cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module convex_hull_brute_force #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  chbf_pkg::in_item_t  in_payload,
  output logic                out_strobe,
  output chbf_pkg::out_item_t out_payload
);
  import chbf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  chbf_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .set_end(in_payload.set_end),
    .busy   (busy),
    .cmd    (cmd),
    .sts    (sts)
  );

  // Store and side test
  chbf_datapath #(
    .MAX_POINTS(MAX_POINTS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_payload (in_payload),
    .out_strobe (out_strobe),
    .out_payload(out_payload)
  );

endmodule

// ===== rtl/core/chbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// chbf_ctrl
// Sequencer: walks the load phase, every point pair, every test point of a
// non-coincident pair, and the final index scan.
// ----------------------------------------------------------------------------
module chbf_ctrl #(
  parameter int MAX_POINTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              set_end,
  output logic              busy,
  output chbf_pkg::dp_cmd_t cmd,
  input  chbf_pkg::dp_sts_t sts
);
  import chbf_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SW    = CNT_W + 1;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_INIT  = 11'b000_0000_0010,
    ST_RD_I  = 11'b000_0000_0100,
    ST_RD_J  = 11'b000_0000_1000,
    ST_LAT_J = 11'b000_0001_0000,
    ST_TEST  = 11'b000_0010_0000,
    ST_SCAN  = 11'b000_0100_0000,
    ST_DRAIN = 11'b000_1000_0000,
    ST_NEXT  = 11'b001_0000_0000,
    ST_EMIT  = 11'b010_0000_0000,
    ST_FLUSH = 11'b100_0000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [SW-1:0]    n_w;

  assign n_w  = SW'(CNT_W'(sts.count));
  assign busy = (state_r != ST_IDLE);

  // Next state, counters and command decode
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.pair_i   = HULL_IDX_W'(i_r);
    cmd.pair_j   = HULL_IDX_W'(j_r);
    cmd.scan_idx = HULL_IDX_W'(k_r);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start && set_end) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        i_nxt = '0;
        j_nxt = IDX_W'(1);
        k_nxt = '0;
        if (n_w < SW'(2)) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_RD_I;
        end
      end
      ST_RD_I: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = HULL_IDX_W'(i_r);
        state_nxt   = ST_RD_J;
      end
      ST_RD_J: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = HULL_IDX_W'(j_r);
        cmd.lat_i   = 1'b1;
        state_nxt   = ST_LAT_J;
      end
      ST_LAT_J: begin
        cmd.lat_j = 1'b1;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        k_nxt = '0;
        if (sts.coincident) begin
          state_nxt = ST_NEXT;
        end else begin
          cmd.set_pair = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = HULL_IDX_W'(k_r);
        cmd.k_issue = 1'b1;
        k_nxt       = k_r + IDX_W'(1);
        if (SW'(k_r) + SW'(1) == n_w) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last cross products to settle the side flags
        if (!sts.pipe_busy) begin
          cmd.mark_pair = !sts.opposite;
          state_nxt     = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (SW'(j_r) + SW'(1) != n_w) begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = ST_RD_I;
        end else if (SW'(i_r) + SW'(3) > n_w) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          j_nxt     = IDX_W'(32'(i_r) + 2);
          state_nxt = ST_RD_I;
        end
      end
      ST_EMIT: begin
        cmd.scan_en = 1'b1;
        k_nxt       = k_r + IDX_W'(1);
        if (SW'(k_r) + SW'(1) == n_w) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

`ifndef SYNTH
  // A pair is decided only once its test pipeline has drained
  a_mark_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_pair |-> (state_r == ST_DRAIN) && !sts.pipe_busy)
    else $error("pair marked before the side test finished");

  // The pair indices always address stored points in order
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_I) |-> (i_r < j_r) && (SW'(j_r) < n_w))
    else $error("pair indices out of order or beyond the stored set");

  // A finished set always ends in a flush and returns to idle
  a_flush_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |=> (state_r == ST_IDLE))
    else $error("flush did not return to idle");
`endif

endmodule

// ===== rtl/core/chbf_datapath.sv =====
// ----------------------------------------------------------------------------
// chbf_datapath
// Point store, pair registers, cross-product side test pipeline, hull marks
// and the result register.
// ----------------------------------------------------------------------------
module chbf_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chbf_pkg::dp_cmd_t   cmd,
  output chbf_pkg::dp_sts_t   sts,
  input  chbf_pkg::in_item_t  in_payload,
  output logic                out_strobe,
  output chbf_pkg::out_item_t out_payload
);
  import chbf_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CW    = COORD_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int PW    = 2 * DW;

  // Reduce an input field to a coordinate of CW bits, as the set defines it
  function automatic logic signed [CW-1:0] to_coord(input logic [COORD_IN_W-1:0] v);
    logic signed [CW-1:0] c;
    c = '0;
    for (int b = 0; b < CW; b++) begin
      c[b] = (b < COORD_IN_W) ? v[b % COORD_IN_W] : 1'b0;
    end
    return c;
  endfunction

  logic [2*CW-1:0]        mem [MAX_POINTS];
  logic [2*CW-1:0]        mem_q_r;
  logic [CNT_W-1:0]       count_r;
  logic                   dropped_r;
  logic [IDX_W-1:0]       least_idx_r;
  logic signed [CW-1:0]   least_x_r;
  logic signed [CW-1:0]   in_x, in_y;
  logic signed [CW-1:0]   xk, yk;
  logic signed [CW-1:0]   xi_r, yi_r, xj_r, yj_r;
  logic signed [DW-1:0]   dx_r, dy_r, ax_r, ay_r;
  logic signed [PW-1:0]   p_r, q_r;
  logic                   v1_r, v2_r, v3_r;
  logic                   pos_r, neg_r;
  logic [MAX_POINTS-1:0]  hull_mark_r;
  logic                   pend_v_r;
  logic [IDX_W-1:0]       pend_idx_r;
  logic                   out_valid_r;
  out_item_t              out_payload_r;
  logic [IDX_W-1:0]       scan_i;
  logic                   scan_hit;
  logic                   room;

  assign in_x     = to_coord(in_payload.x_coord);
  assign in_y     = to_coord(in_payload.y_coord);
  assign xk       = mem_q_r[2*CW-1:CW];
  assign yk       = mem_q_r[CW-1:0];
  assign room     = (count_r < CNT_W'(MAX_POINTS));
  assign scan_i   = cmd.scan_idx[IDX_W-1:0];
  assign scan_hit = hull_mark_r[scan_i] || (scan_i == least_idx_r);

  assign sts.count      = CNT_FIELD_W'(count_r);
  assign sts.pipe_busy  = v1_r || v2_r || v3_r;
  assign sts.coincident = (xi_r == xj_r) && (yi_r == yj_r);
  assign sts.opposite   = pos_r && neg_r;

  assign out_strobe  = out_valid_r;
  assign out_payload = out_payload_r;

  // Point store: write on load, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[count_r[IDX_W-1:0]] <= {in_x, in_y};
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[cmd.rd_addr[IDX_W-1:0]];
    end
  end

  // Track the first point of least x while loading
  always_ff @(posedge clk) begin
    if (cmd.load && room && ((count_r == '0) || (in_x < least_x_r))) begin
      least_idx_r <= count_r[IDX_W-1:0];
      least_x_r   <= in_x;
    end
  end

  // Capture the pair end points and their direction
  always_ff @(posedge clk) begin
    if (cmd.lat_i) begin
      xi_r <= xk;
      yi_r <= yk;
    end
    if (cmd.lat_j) begin
      xj_r <= xk;
      yj_r <= yk;
    end
    if (cmd.set_pair) begin
      dx_r <= $signed({xj_r[CW-1], xj_r}) - $signed({xi_r[CW-1], xi_r});
      dy_r <= $signed({yj_r[CW-1], yj_r}) - $signed({yi_r[CW-1], yi_r});
    end
  end

  // Side test pipeline: offsets, products, compare
  always_ff @(posedge clk) begin
    ax_r <= $signed({xk[CW-1], xk}) - $signed({xi_r[CW-1], xi_r});
    ay_r <= $signed({yk[CW-1], yk}) - $signed({yi_r[CW-1], yi_r});
    p_r  <= ax_r * dy_r;
    q_r  <= ay_r * dx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
      pos_r <= 1'b0;
      neg_r <= 1'b0;
    end else begin
      v1_r <= cmd.k_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.set_pair) begin
        pos_r <= 1'b0;
        neg_r <= 1'b0;
      end else if (v3_r) begin
        pos_r <= pos_r || (p_r > q_r);
        neg_r <= neg_r || (p_r < q_r);
      end
    end
  end

  // Set control: fill count, drop flag, hull marks, pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      dropped_r   <= 1'b0;
      hull_mark_r <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cmd.load) begin
        if (room) begin
          count_r <= count_r + CNT_W'(1);
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (cmd.mark_pair) begin
        hull_mark_r[cmd.pair_i[IDX_W-1:0]] <= 1'b1;
        hull_mark_r[cmd.pair_j[IDX_W-1:0]] <= 1'b1;
      end
      // hold one found index back so the last one can carry run_end
      if (cmd.scan_en && scan_hit) begin
        pend_v_r   <= 1'b1;
        pend_idx_r <= scan_i;
        if (pend_v_r) begin
          out_valid_r <= 1'b1;
        end
      end
      if (cmd.flush) begin
        out_valid_r <= pend_v_r;
        pend_v_r    <= 1'b0;
        count_r     <= '0;
        dropped_r   <= 1'b0;
        hull_mark_r <= '0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if ((cmd.scan_en && scan_hit && pend_v_r) || cmd.flush) begin
      out_payload_r.hull_index <= HULL_IDX_W'(pend_idx_r);
      out_payload_r.run_end    <= cmd.flush;
      out_payload_r.overflow   <= dropped_r;
    end
  end

`ifndef SYNTH
  // Every set ends with a result that carries run_end
  a_flush_emits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> out_valid_r && out_payload_r.run_end)
    else $error("set ended without a final result");

  // Side flags are cleared only when no test point is in flight
  a_clear_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.set_pair |-> !(v1_r || v2_r || v3_r))
    else $error("side flags cleared with test points in flight");

  // The fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond capacity");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives point sets into the brute-force convex hull marker and checks each
// reported hull index against an in-bench hull predictor. Covers corner
// coordinates, degenerate sets, store overflow and random sets with random
// sender gaps.
// ----------------------------------------------------------------------------
module testbench;
  import chbf_pkg::*;

  localparam int MAX_PTS     = 64;
  localparam int QUIET_LIMIT = 500000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_payload;
  logic      out_strobe;
  out_item_t out_payload;

  convex_hull_brute_force #(
    .MAX_POINTS(MAX_PTS),
    .COORD_BITS(COORD_IN_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_strobe (out_strobe),
    .out_payload(out_payload)
  );

  // Predictor state: the current set as the block should hold it
  logic signed [COORD_IN_W-1:0] pts_x [MAX_PTS];
  logic signed [COORD_IN_W-1:0] pts_y [MAX_PTS];
  int        pts_n;
  bit        pts_dropped;
  out_item_t hull_expect[$];

  int err_count;
  int quiet_cycles;
  bit no_idle;

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Store one point, and on set end mark the hull and queue its indices
  function automatic void take_point(in_item_t it);
    bit        marked [MAX_PTS];
    int        least;
    longint    dx, dy, p, q;
    bit        pos, neg;
    out_item_t row;
    int        last_pos;
    if (pts_n < MAX_PTS) begin
      pts_x[pts_n] = it.x_coord;
      pts_y[pts_n] = it.y_coord;
      pts_n++;
    end else begin
      pts_dropped = 1'b1;
    end
    if (!it.set_end) return;

    foreach (marked[m]) marked[m] = 1'b0;
    // The first point of least x is always on the hull
    least = 0;
    for (int i = 1; i < pts_n; i++)
      if (pts_x[i] < pts_x[least]) least = i;
    marked[least] = 1'b1;

    // Mark both ends of every pair whose line has no points on both sides
    for (int i = 0; i + 1 < pts_n; i++) begin
      for (int j = i + 1; j < pts_n; j++) begin
        dx = longint'(pts_x[j]) - longint'(pts_x[i]);
        dy = longint'(pts_y[j]) - longint'(pts_y[i]);
        if (dx == 0 && dy == 0) continue;
        pos = 1'b0;
        neg = 1'b0;
        for (int k = 0; k < pts_n; k++) begin
          p = (longint'(pts_x[k]) - longint'(pts_x[i])) * dy;
          q = (longint'(pts_y[k]) - longint'(pts_y[i])) * dx;
          if (p > q) pos = 1'b1;
          else if (p < q) neg = 1'b1;
        end
        if (!(pos && neg)) begin
          marked[i] = 1'b1;
          marked[j] = 1'b1;
        end
      end
    end

    // Queue marked indices in ascending order, flag the last one
    last_pos = -1;
    for (int i = 0; i < pts_n; i++) begin
      if (marked[i]) begin
        row.hull_index = HULL_IDX_W'(i);
        row.run_end    = 1'b0;
        row.overflow   = pts_dropped;
        hull_expect    = {hull_expect, row};
        last_pos = hull_expect.size() - 1;
      end
    end
    if (last_pos >= 0) hull_expect[last_pos].run_end = 1'b1;
    pts_n       = 0;
    pts_dropped = 1'b0;
  endfunction

  // Send one point, with an optional random gap ahead of it
  task automatic send_point(input logic signed [COORD_IN_W-1:0] x,
                            input logic signed [COORD_IN_W-1:0] y,
                            input bit last);
    int       gap;
    in_item_t it;
    it  = in_item_t'{x_coord: x, y_coord: y, set_end: last};
    gap = 0;
    // keep adding an idle cycle ahead of the point while a draw with 36 percent odds hits
    if (!no_idle) begin
      while ($urandom_range(99) < 36) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    in_payload <= it;
    do @(posedge clk); while (!(start && !busy));
    take_point(it);
  endtask

  // Pick a coordinate: full range, tight grid, extremes or near extremes
  function automatic logic signed [COORD_IN_W-1:0] pick_coord(int mode);
    logic signed [COORD_IN_W-1:0] corners [7];
    corners = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1,
                16'sd32766, 16'sd32767};
    case (mode)
      0: return COORD_IN_W'($urandom);
      1: return COORD_IN_W'(int'($urandom_range(6)) - 3);
      2: return corners[$urandom_range(6)];
      default: begin
        if ($urandom_range(1)) return COORD_IN_W'(32767 - int'($urandom_range(40)));
        else return COORD_IN_W'(-32768 + int'($urandom_range(40)));
      end
    endcase
  endfunction

  // Corners of the coordinate range with one interior point
  task automatic test_extreme_corners();
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point( 16'sd32767,  16'sd32767, 1'b0);
    send_point(-16'sd32768,  16'sd32767, 1'b0);
    send_point( 16'sd32767, -16'sd32768, 1'b0);
    send_point( 16'sd0,      16'sd0,     1'b1);
  endtask

  // Single point, two points, coincident, collinear, tied least x
  task automatic test_degenerate_sets();
    send_point(16'sd12, -16'sd7, 1'b1);
    send_point(16'sd3, 16'sd4, 1'b0);
    send_point(-16'sd3, -16'sd4, 1'b1);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd7, 16'sd1, 1'b1);
    send_point(-16'sd9, 16'sd2, 1'b0);
    send_point(-16'sd9, 16'sd2, 1'b1);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd1, 1'b0);
    send_point(16'sd0, 16'sd3, 1'b0);
    send_point(16'sd0, 16'sd2, 1'b1);
    send_point(16'sd2, 16'sd1, 1'b0);
    send_point(-16'sd5, 16'sd3, 1'b0);
    send_point(-16'sd5, 16'sd0, 1'b1);
  endtask

  // Fill the store, then drop two points, the set end among them
  task automatic test_capacity_overflow();
    for (int n = 0; n < MAX_PTS; n++) send_point(pick_coord(0), pick_coord(0), 1'b0);
    send_point(pick_coord(0), pick_coord(0), 1'b0);
    send_point(pick_coord(0), pick_coord(0), 1'b1);
  endtask

  // Random sets, mostly small, with one stretch of back-to-back traffic
  task automatic test_random_sets(input int item_goal);
    int sent, size, mode, sets;
    sent = 0;
    sets = 0;
    while (sent < item_goal) begin
      no_idle = (sets >= 5 && sets < 15);
      size = ($urandom_range(9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
      mode = $urandom_range(3);
      for (int k = 0; k < size; k++)
        send_point(pick_coord(mode), pick_coord(mode), k == size - 1);
      sent += size;
      sets++;
    end
    no_idle = 1'b0;
  endtask

  // Check each result against the oldest expectation; watch for a hang
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (hull_expect.size() == 0) begin
          $error("hull_index: no result expected, got %0d", out_payload.hull_index);
          err_count++;
        end else begin
          want = hull_expect.pop_front();
          if (out_payload.hull_index !== want.hull_index) begin
            $error("hull_index: expected %0d, got %0d",
                   want.hull_index, out_payload.hull_index);
            err_count++;
          end
          if (out_payload.run_end !== want.run_end) begin
            $error("run_end: expected %0d, got %0d", want.run_end, out_payload.run_end);
            err_count++;
          end
          if (out_payload.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_payload.overflow);
            err_count++;
          end
        end
      end
      if (out_strobe || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    start        <= 1'b0;
    in_payload   <= '0;
    rst_n        <= 1'b0;
    pts_n        = 0;
    pts_dropped  = 1'b0;
    err_count    = 0;
    quiet_cycles = 0;
    no_idle      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extreme_corners();
    test_degenerate_sets();
    test_capacity_overflow();
    test_random_sets(200);

    start <= 1'b0;
    while (hull_expect.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
